### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/rgr_pkg.sv
package rgr_pkg;

  localparam int GAP_W  = 6;
  localparam int BYTE_W = 8;
  localparam int ERR_W  = 3;
  localparam int IDX_W  = 5;
  localparam int LEN_W  = 6;

  localparam logic [GAP_W-1:0] GAP_RESET = 6'd16;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
    logic [ERR_W-1:0]  line_errors;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  frame_length;
    logic              last;
    logic              overflow_seen;
  } out_t;

endpackage

### design/rgr_frame_ram.sv
module rgr_frame_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [rgr_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [rgr_pkg::BYTE_W-1:0] rd_data
);

  logic [rgr_pkg::BYTE_W-1:0] mem_r [DEPTH];
  logic [rgr_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/rs485_frame_gap_receiver.sv
// Byte and non-ending tick transactions produce no result.
// Frame-ending tick: first result in the cycle after acceptance, then one result per
// cycle while out_stall is low, from the frame RAM read port (N results for N
// stored bytes, one if empty). Input is stalled while a frame is being emitted.
// Reset (synchronous, rst_n low): counters and overflow flag clear, gap reg = 16;
// frame RAM contents are not cleared.
module rs485_frame_gap_receiver #(
  parameter int BUFFER_DEPTH = 32,
  parameter int SILENCE_CAP  = 50
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rgr_pkg::GAP_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rgr_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rgr_pkg::out_t                 out_data
);

`include "assert_macros.svh"

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int POS_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int SIL_W  = $clog2(SILENCE_CAP + 1);
  localparam int CMP_W  = (SIL_W > rgr_pkg::GAP_W) ? SIL_W : rgr_pkg::GAP_W;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                     state_r;
  logic [rgr_pkg::GAP_W-1:0]  gap_r;
  logic [POS_W-1:0]           wpos_r;
  logic [ADDR_W-1:0]          gcnt_r;
  logic [SIL_W-1:0]           sil_r;
  logic                       ovf_r;
  logic [ADDR_W-1:0]          idx_r;
  logic [POS_W-1:0]           len_r;
  logic                       out_valid_r;

  logic                       in_acc;
  logic                       out_acc;
  logic                       good_byte;
  logic                       tick;
  logic                       sil_at_cap;
  logic [SIL_W-1:0]           sil_inc;
  logic                       frame_end;
  logic                       store_full;
  logic                       last;
  logic                       wr_en;
  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic [rgr_pkg::BYTE_W-1:0] rd_data;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_acc    = out_valid_r && !out_stall;

  assign good_byte  = in_acc && (in_data.func == rgr_pkg::FUNC_BYTE) &&
                      (in_data.line_errors == '0);
  assign tick       = in_acc && (in_data.func == rgr_pkg::FUNC_TICK);
  assign sil_at_cap = (sil_r == SIL_W'(SILENCE_CAP));
  assign sil_inc    = sil_r + SIL_W'(1);
  assign frame_end  = tick && !sil_at_cap && (CMP_W'(sil_inc) == CMP_W'(gap_r));
  assign store_full = (wpos_r == POS_W'(BUFFER_DEPTH));
  assign last       = (len_r == '0) || ((POS_W'(idx_r) + POS_W'(1)) == len_r);

  // RAM writes happen only in idle and reads only after a later transaction,
  // so a read never overlaps a write to the same entry.
  assign wr_en   = good_byte && !store_full;
  assign rd_en   = frame_end || ((state_r == ST_EMIT) && out_acc && !last);
  assign rd_addr = frame_end ? '0 : (idx_r + ADDR_W'(1));

  rgr_frame_ram #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wpos_r[ADDR_W-1:0]),
    .wr_data (in_data.rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gap_r       <= rgr_pkg::GAP_RESET;
      wpos_r      <= '0;
      gcnt_r      <= '0;
      sil_r       <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (good_byte) begin
            if (!store_full) begin
              wpos_r <= wpos_r + POS_W'(1);
            end
            if (gcnt_r == ADDR_W'(BUFFER_DEPTH - 1)) begin
              gcnt_r <= '0;
              ovf_r  <= 1'b1;
            end else begin
              gcnt_r <= gcnt_r + ADDR_W'(1);
            end
            sil_r <= '0;
          end
          if (tick && !sil_at_cap) begin
            sil_r <= sil_inc;
          end
          if (frame_end) begin
            len_r       <= wpos_r;
            idx_r       <= '0;
            wpos_r      <= '0;
            gcnt_r      <= '0;
            out_valid_r <= 1'b1;
            state_r     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (last) begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              idx_r <= idx_r + ADDR_W'(1);
            end
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_data.frame_byte    = (len_r == '0) ? '0 : rd_data;
    out_data.byte_index    = rgr_pkg::IDX_W'(idx_r);
    out_data.frame_length  = rgr_pkg::LEN_W'(len_r);
    out_data.last          = last;
    out_data.overflow_seen = ovf_r;
  end

  `ASSERT_NXT(a_end_starts_emit, clk, rst_n, frame_end, out_valid_r && (idx_r == '0))
  `ASSERT_NXT(a_last_ends_emit, clk, rst_n, out_acc && last, !out_valid_r && !in_stall)
  `ASSERT_NXT(a_index_steps, clk, rst_n, out_acc && !last,
              out_valid_r && (idx_r == ($past(idx_r) + ADDR_W'(1))))
  `ASSERT_IMP(a_index_in_frame, clk, rst_n, out_valid_r && (len_r != '0),
              POS_W'(idx_r) < len_r)

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgr_pkg::*;

  localparam int BUF_DEPTH    = 32;
  localparam int SIL_CAP      = 50;
  localparam int LIMIT_CYCLES = 200000;

  class frame_scoreboard;
    logic [BYTE_W-1:0] store [BUF_DEPTH];
    int                wr_pos   = 0;
    int                good_cnt = 0;
    int                silence  = 0;
    logic              overflow = 1'b0;
    logic [GAP_W-1:0]  gap      = GAP_RESET;
    out_t              pending [$];
    int                errors   = 0;
    int                inputs   = 0;
    int                frames   = 0;
    int                results  = 0;
    int                settings = 0;

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void note_input(in_t it);
      out_t r;
      inputs++;
      if (it.func == FUNC_BYTE) begin
        if (it.line_errors != '0) return;
        if (wr_pos < BUF_DEPTH) begin
          store[wr_pos] = it.rx_byte;
          wr_pos++;
        end
        good_cnt++;
        if (good_cnt >= BUF_DEPTH) begin
          good_cnt = 0;
          overflow = 1'b1;
        end
        silence = 0;
        return;
      end
      if (silence >= SIL_CAP) return;
      silence++;
      if (silence != int'(gap)) return;
      frames++;
      if (wr_pos == 0) begin
        r = '0;
        r.last = 1'b1;
        r.overflow_seen = overflow;
        pending.push_back(r);
      end else begin
        for (int k = 0; k < wr_pos; k++) begin
          r.frame_byte    = store[k];
          r.byte_index    = IDX_W'(k);
          r.frame_length  = LEN_W'(wr_pos);
          r.last          = (k + 1 == wr_pos);
          r.overflow_seen = overflow;
          pending.push_back(r);
        end
      end
      wr_pos   = 0;
      good_cnt = 0;
    endfunction

    task check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      exp = pending.pop_front();
      results++;
      if (got.frame_byte !== exp.frame_byte)
        report_mismatch($sformatf("frame_byte %h, expected %h", got.frame_byte,
                                  exp.frame_byte));
      if (got.byte_index !== exp.byte_index)
        report_mismatch($sformatf("byte_index %0d, expected %0d", got.byte_index,
                                  exp.byte_index));
      if (got.frame_length !== exp.frame_length)
        report_mismatch($sformatf("frame_length %0d, expected %0d", got.frame_length,
                                  exp.frame_length));
      if (got.last !== exp.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, exp.last));
      if (got.overflow_seen !== exp.overflow_seen)
        report_mismatch($sformatf("overflow_seen %b, expected %b", got.overflow_seen,
                                  exp.overflow_seen));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [GAP_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;

  frame_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;

  rs485_frame_gap_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  function automatic in_t make_item(logic f, logic [BYTE_W-1:0] b, logic [ERR_W-1:0] e);
    in_t it;
    it.func        = f;
    it.rx_byte     = b;
    it.line_errors = e;
    return it;
  endfunction

  function automatic in_t rand_tick();
    return make_item(FUNC_TICK, BYTE_W'($urandom_range(255)), ERR_W'($urandom_range(7)));
  endfunction

  task automatic drive_item(input in_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  // only while idle: drain results, then idle slack before the gap write
  task automatic write_gap(input logic [GAP_W-1:0] g);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.gap = g;
    sb.settings++;
  endtask

  // good bytes with optional errored bytes and stray ticks, then a tick run
  task automatic send_frame(input int nbytes, input bit noisy, input int nticks);
    for (int i = 0; i < nbytes; i++) begin
      if (noisy && $urandom_range(9) == 0)
        drive_item(make_item(FUNC_BYTE, BYTE_W'($urandom_range(255)),
                             ERR_W'($urandom_range(7, 1))));
      if (noisy && $urandom_range(19) == 0) drive_item(rand_tick());
      drive_item(make_item(FUNC_BYTE, BYTE_W'($urandom_range(255)), '0));
    end
    repeat (nticks) drive_item(rand_tick());
  endtask

  task automatic run_frames(input int nframes, input int gap_lo, input int gap_hi);
    int g;
    write_gap(GAP_W'($urandom_range(gap_hi, gap_lo)));
    g = int'(sb.gap);
    for (int f = 0; f < nframes; f++) begin
      if ($urandom_range(5) == 0)
        send_frame($urandom_range(8), 1'b1, $urandom_range(g));
      else
        send_frame($urandom_range(8), 1'b1, g + $urandom_range(2));
    end
  endtask

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run exceeded %0d cycles", LIMIT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 33;
    rx_idle_pct = 50;
    // silence starts at zero, so the reset gap alone closes an empty frame
    repeat (16) drive_item(rand_tick());
    write_gap(GAP_W'(1));
    drive_item(make_item(FUNC_BYTE, 8'h00, 3'b000));
    drive_item(make_item(FUNC_BYTE, 8'hFF, 3'b000));
    drive_item(make_item(FUNC_BYTE, 8'h55, 3'b001));
    drive_item(make_item(FUNC_BYTE, 8'hAA, 3'b010));
    drive_item(make_item(FUNC_BYTE, 8'h7E, 3'b100));
    drive_item(make_item(FUNC_BYTE, 8'h81, 3'b111));
    drive_item(make_item(FUNC_TICK, 8'hFF, 3'b111));
    drive_item(make_item(FUNC_TICK, 8'h00, 3'b000));
    drive_item(make_item(FUNC_BYTE, 8'h80, 3'b000));
    drive_item(rand_tick());
    // raising the gap above the current silence yields an empty frame
    write_gap(GAP_W'(3));
    repeat (2) drive_item(rand_tick());

    run_frames(2, 2, 8);
    write_gap(GAP_W'(49));
    send_frame(3, 1'b0, SIL_CAP + 2);

    tx_idle_pct = 50;
    rx_idle_pct = 33;
    run_frames(2, 1, 10);
    write_gap(GAP_W'(2));
    send_frame(BUF_DEPTH - 1, 1'b0, 2);
    // out-of-range gaps never close a frame; the store fills and overflows
    write_gap(GAP_W'(0));
    send_frame(3, 1'b1, 5);
    write_gap(GAP_W'(63));
    send_frame(30, 1'b0, 8);
    write_gap(GAP_W'(4));
    send_frame(1, 1'b0, 4);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_frames(2, 1, 6);
    write_gap(GAP_W'(3));
    send_frame(BUF_DEPTH, 1'b0, 3);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d input transactions, %0d frames closed, %0d result transactions checked",
             sb.inputs, sb.frames, sb.results);
    $display("%0d gap settings used, %0d mismatches", sb.settings, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/rgr_pkg.sv
design/rgr_frame_ram.sv
design/rs485_frame_gap_receiver.sv
sim/testbench.sv
